### rtl/core/sws_pkg.sv
// shared types and constants of the sliding window sender
`timescale 1ns / 1ps

package sws_pkg;

    localparam int DEF_WINDOW_SIZE  = 4;
    localparam int DEF_SEQ_BITS     = 8;
    localparam int DEF_PAYLOAD_BITS = 32;

    localparam int REQ_BITS     = 2;
    localparam int ACK_BITS     = 8;
    localparam int OUT_SEQ_BITS = 8;
    localparam int THR_BITS     = 4;
    localparam int TMR_BITS     = 2;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(3);

    typedef enum logic [REQ_BITS-1:0] {
        REQ_SEND    = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_NOP     = 2'd3
    } t_req;

    typedef enum logic [TMR_BITS-1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } t_timer_cmd;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_OUTS = 3'd1,
        ST_OFF  = 3'd2,
        ST_EXEC = 3'd3,
        ST_EMIT = 3'd4,
        ST_READ = 3'd5
    } t_state;

endpackage

### rtl/core/sws_alu.sv
// shared modular add / subtract unit for sequence numbers
`timescale 1ns / 1ps

module sws_alu #(
    parameter int SEQ_BITS = sws_pkg::DEF_SEQ_BITS
) (
    input  sws_pkg::t_alu_op     i_op,
    input  logic [SEQ_BITS-1:0]  i_a,
    input  logic [SEQ_BITS-1:0]  i_b,
    output logic [SEQ_BITS-1:0]  o_y
);
    import sws_pkg::*;

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a - i_b;
        endcase
    end

endmodule

### rtl/core/sws_ring.sv
// circular payload store of outstanding packets with registered read
`timescale 1ns / 1ps

module sws_ring #(
    parameter int WINDOW_SIZE  = sws_pkg::DEF_WINDOW_SIZE,
    parameter int PAYLOAD_BITS = sws_pkg::DEF_PAYLOAD_BITS,
    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1,
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [IDX_W-1:0]        i_head,
    input  logic [CNT_W-1:0]        i_wr_off,
    input  logic [CNT_W-1:0]        i_rd_off,
    input  logic [PAYLOAD_BITS-1:0] i_wr_data,
    output logic [PAYLOAD_BITS-1:0] o_rd_data
);
    import sws_pkg::*;

    localparam int SUM_W = $clog2(2 * WINDOW_SIZE);
    localparam logic [SUM_W-1:0] W_SUM = SUM_W'(WINDOW_SIZE);

    logic [PAYLOAD_BITS-1:0] mem [WINDOW_SIZE];
    logic [SUM_W-1:0]        wr_sum;
    logic [SUM_W-1:0]        rd_sum;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        rd_addr;

    // offsets stay below the window, so one conditional subtract wraps
    always_comb begin
        wr_sum  = SUM_W'(i_head) + SUM_W'(i_wr_off);
        rd_sum  = SUM_W'(i_head) + SUM_W'(i_rd_off);
        wr_addr = IDX_W'((wr_sum >= W_SUM) ? (wr_sum - W_SUM) : wr_sum);
        rd_addr = IDX_W'((rd_sum >= W_SUM) ? (rd_sum - W_SUM) : rd_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/sliding_window_sender.sv
// go-back-n sender with fast retransmit: sequencer, window state and result register
//
//   channel   direction  handshake                 carries
//   request   in         i_in_valid / o_in_stall   req_type, payload, ack_number, checksum_ok
//   result    out        o_out_valid / i_out_stall accepted .. last
//   config    in         i_cfg_valid / o_cfg_ready dup_ack_threshold
//
// one transaction at a time; the shared add/subtract unit is used three times per step
// send, ack, idle and empty-window timeout requests: OUTS, OFF, EXEC, EMIT, then idle
// timeout with n >= 1 packets outstanding: one EXEC, EMIT pair and one ring read per packet
// synchronous active-low reset; base and next sequence start at 1, threshold at 3
// an output stall holds the sequencer in its result state

`timescale 1ns / 1ps

module sliding_window_sender #(
    parameter int WINDOW_SIZE  = sws_pkg::DEF_WINDOW_SIZE,
    parameter int SEQ_BITS     = sws_pkg::DEF_SEQ_BITS,
    parameter int PAYLOAD_BITS = sws_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sws_pkg::REQ_BITS-1:0]     i_req_type,
    input  logic [PAYLOAD_BITS-1:0]          i_payload,
    input  logic [sws_pkg::ACK_BITS-1:0]     i_ack_number,
    input  logic                             i_checksum_ok,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_accepted,
    output logic                             o_window_full,
    output logic                             o_tx_valid,
    output logic [sws_pkg::OUT_SEQ_BITS-1:0] o_tx_seq,
    output logic [PAYLOAD_BITS-1:0]          o_tx_payload,
    output logic [sws_pkg::TMR_BITS-1:0]     o_timer_cmd,
    output logic [sws_pkg::OUT_SEQ_BITS-1:0] o_timer_seq,
    output logic                             o_last,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sws_pkg::THR_BITS-1:0]     i_cfg_data
);
    import sws_pkg::*;

    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W = $clog2(2 * WINDOW_SIZE);
    localparam int OSEQ  = OUT_SEQ_BITS;

    localparam logic [CNT_W-1:0]    W_CNT   = CNT_W'(WINDOW_SIZE);
    localparam logic [SUM_W-1:0]    W_SUM   = SUM_W'(WINDOW_SIZE);
    localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);

    t_state                  r_state, n_state;
    t_req                    r_req;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [SEQ_BITS-1:0]     r_ack;
    logic                    r_ok;
    logic [SEQ_BITS-1:0]     r_base, n_base;
    logic [SEQ_BITS-1:0]     r_next, n_next;
    logic [IDX_W-1:0]        r_head, n_head;
    logic [THR_BITS-1:0]     r_dup, n_dup;
    logic [THR_BITS-1:0]     r_thr;
    logic [CNT_W-1:0]        r_outs;
    logic [SEQ_BITS-1:0]     r_off;
    logic [CNT_W-1:0]        r_idx;

    logic                    r_accepted, n_accepted;
    logic                    r_window_full, n_window_full;
    logic                    r_tx_valid, n_tx_valid;
    logic [OSEQ-1:0]         r_tx_seq, n_tx_seq;
    logic [PAYLOAD_BITS-1:0] r_tx_payload, n_tx_payload;
    t_timer_cmd              r_timer_cmd, n_timer_cmd;
    logic [OSEQ-1:0]         r_timer_seq, n_timer_seq;
    logic                    r_last, n_last;

    logic                    in_acc;
    logic                    cfg_we;
    t_alu_op                 alu_op;
    logic [SEQ_BITS-1:0]     alu_a, alu_b, alu_y;
    logic                    ring_we;
    logic [PAYLOAD_BITS-1:0] ring_rd_data;
    logic [THR_BITS-1:0]     dup_inc;
    logic [SUM_W-1:0]        head_sum;

    sws_alu #(
        .SEQ_BITS (SEQ_BITS)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    sws_ring #(
        .WINDOW_SIZE  (WINDOW_SIZE),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ring_we),
        .i_head    (r_head),
        .i_wr_off  (r_outs),
        .i_rd_off  (r_idx),
        .i_wr_data (r_pay),
        .o_rd_data (ring_rd_data)
    );

    assign in_acc = i_in_valid && !o_in_stall;
    assign cfg_we = i_cfg_valid && o_cfg_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_OUTS;
                end
            end
            ST_OUTS: n_state = ST_OFF;
            ST_OFF:  n_state = ST_EXEC;
            ST_EXEC: n_state = ST_EMIT;
            ST_EMIT: begin
                if (!i_out_stall) begin
                    n_state = r_last ? ST_IDLE : ST_READ;
                end
            end
            ST_READ: n_state = ST_EXEC;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs and shared unit operands
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_cfg_ready = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_EMIT);
        alu_op      = ALU_SUB;
        alu_a       = r_next;
        alu_b       = r_base;
        unique case (r_state)
            ST_OFF: begin
                alu_a = r_ack;
            end
            ST_EXEC: begin
                alu_op = ALU_ADD;
                unique case (r_req)
                    REQ_SEND: begin
                        alu_a = r_next;
                        alu_b = SEQ_ONE;
                    end
                    REQ_ACK: begin
                        alu_a = r_ack;
                        alu_b = SEQ_ONE;
                    end
                    REQ_TIMEOUT: begin
                        alu_a = r_base;
                        alu_b = SEQ_BITS'(r_idx);
                    end
                    REQ_NOP: begin
                        alu_a = r_base;
                        alu_b = SEQ_ONE;
                    end
                    default: begin
                        alu_a = r_base;
                        alu_b = SEQ_ONE;
                    end
                endcase
            end
            default: begin
                alu_op = ALU_SUB;
            end
        endcase
    end

    // result and window update of one step
    always_comb begin
        n_accepted    = 1'b0;
        n_tx_valid    = 1'b0;
        n_tx_seq      = '0;
        n_tx_payload  = '0;
        n_timer_cmd   = TMR_NONE;
        n_timer_seq   = '0;
        n_last        = 1'b1;
        n_window_full = (r_outs == W_CNT);
        n_base        = r_base;
        n_next        = r_next;
        n_head        = r_head;
        n_dup         = r_dup;
        ring_we       = 1'b0;
        dup_inc       = r_dup + THR_BITS'(1);
        head_sum      = SUM_W'(r_head) + SUM_W'(r_off) + SUM_W'(1);

        unique case (r_req)
            REQ_SEND: begin
                if (r_outs < W_CNT) begin
                    n_accepted    = 1'b1;
                    n_tx_valid    = 1'b1;
                    n_tx_seq      = OSEQ'(r_next);
                    n_tx_payload  = r_pay;
                    n_next        = alu_y;
                    n_window_full = (r_outs == W_CNT - CNT_W'(1));
                    ring_we       = (r_state == ST_EXEC);
                    if (r_outs == '0) begin
                        n_timer_cmd = TMR_START;
                        n_timer_seq = OSEQ'(r_next);
                    end
                end
            end
            REQ_ACK: begin
                if (r_ok && (r_off < SEQ_BITS'(r_outs))) begin
                    // cumulative ack slides the window
                    n_base        = alu_y;
                    n_dup         = '0;
                    n_head        = IDX_W'((head_sum >= W_SUM) ? (head_sum - W_SUM) : head_sum);
                    n_window_full = 1'b0;
                    if (r_off == SEQ_BITS'(r_outs) - SEQ_ONE) begin
                        n_timer_cmd = TMR_STOP;
                        n_timer_seq = OSEQ'(r_base);
                    end else begin
                        n_timer_cmd = TMR_RESTART;
                        n_timer_seq = OSEQ'(alu_y);
                    end
                end else if (r_ok && (r_outs != '0) && (r_off == '1)) begin
                    // duplicate of base - 1
                    if (dup_inc >= r_thr) begin
                        n_dup        = '0;
                        n_tx_valid   = 1'b1;
                        n_tx_seq     = OSEQ'(r_base);
                        n_tx_payload = ring_rd_data;
                        n_timer_cmd  = TMR_RESTART;
                        n_timer_seq  = OSEQ'(r_base);
                    end else begin
                        n_dup = dup_inc;
                    end
                end
            end
            REQ_TIMEOUT: begin
                if (r_outs != '0) begin
                    n_tx_valid   = 1'b1;
                    n_tx_seq     = OSEQ'(alu_y);
                    n_tx_payload = ring_rd_data;
                    n_last       = ((r_idx + CNT_W'(1)) == r_outs);
                    if (r_idx == '0) begin
                        n_timer_cmd = TMR_RESTART;
                        n_timer_seq = OSEQ'(r_base);
                    end
                end
            end
            REQ_NOP: begin
                n_last = 1'b1;
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_base  <= SEQ_ONE;
            r_next  <= SEQ_ONE;
            r_head  <= '0;
            r_dup   <= '0;
            r_thr   <= THR_RESET;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (r_state == ST_EXEC) begin
                r_base <= n_base;
                r_next <= n_next;
                r_head <= n_head;
                r_dup  <= n_dup;
            end
            if (in_acc) begin
                r_idx <= '0;
            end else if ((r_state == ST_EMIT) && !i_out_stall) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= t_req'(i_req_type);
            r_pay <= i_payload;
            r_ack <= SEQ_BITS'(i_ack_number);
            r_ok  <= i_checksum_ok;
        end
        if (r_state == ST_OUTS) begin
            r_outs <= CNT_W'(alu_y);
        end
        if (r_state == ST_OFF) begin
            r_off <= alu_y;
        end
        if (r_state == ST_EXEC) begin
            r_accepted    <= n_accepted;
            r_window_full <= n_window_full;
            r_tx_valid    <= n_tx_valid;
            r_tx_seq      <= n_tx_seq;
            r_tx_payload  <= n_tx_payload;
            r_timer_cmd   <= n_timer_cmd;
            r_timer_seq   <= n_timer_seq;
            r_last        <= n_last;
        end
    end

    assign o_accepted    = r_accepted;
    assign o_window_full = r_window_full;
    assign o_tx_valid    = r_tx_valid;
    assign o_tx_seq      = r_tx_seq;
    assign o_tx_payload  = r_tx_payload;
    assign o_timer_cmd   = r_timer_cmd;
    assign o_timer_seq   = r_timer_seq;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SEQ_BITS'(r_next - r_base) <= SEQ_BITS'(WINDOW_SIZE)))
        else $error("outstanding packets exceed the window");

    a_base_moves_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EXEC) |=> $stable(r_base))
        else $error("base sequence changed outside the execute step");

    a_accept_sends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> o_tx_valid)
        else $error("accepted send without a packet");

    a_timer_matches_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tx_valid && (o_timer_cmd != TMR_NONE)) |-> (o_tx_seq == o_timer_seq))
        else $error("timer command refers to another packet");

    a_multi_only_resend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_tx_valid && (r_req == REQ_TIMEOUT)))
        else $error("non-final result outside a timeout resend");
`endif

endmodule

### dv/sliding_window_sender_tb.sv
// self-checking testbench for the go-back-n sliding window sender
`timescale 1ns / 1ps

module sliding_window_sender_tb;

    import sws_pkg::*;

    localparam int WIN = DEF_WINDOW_SIZE;
    localparam int SW  = DEF_SEQ_BITS;
    localparam int PW  = DEF_PAYLOAD_BITS;

    typedef struct {
        t_req                req_type;
        logic [PW-1:0]       payload;
        logic [ACK_BITS-1:0] ack_number;
        logic                checksum_ok;
    } link_req_t;

    typedef struct {
        logic                    accepted;
        logic                    window_full;
        logic                    tx_valid;
        logic [OUT_SEQ_BITS-1:0] tx_seq;
        logic [PW-1:0]           tx_payload;
        t_timer_cmd              timer_cmd;
        logic [OUT_SEQ_BITS-1:0] timer_seq;
        logic                    last;
    } link_result_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [REQ_BITS-1:0]     i_req_type = '0;
    logic [PW-1:0]           i_payload = '0;
    logic [ACK_BITS-1:0]     i_ack_number = '0;
    logic                    i_checksum_ok = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_accepted;
    logic                    o_window_full;
    logic                    o_tx_valid;
    logic [OUT_SEQ_BITS-1:0] o_tx_seq;
    logic [PW-1:0]           o_tx_payload;
    logic [TMR_BITS-1:0]     o_timer_cmd;
    logic [OUT_SEQ_BITS-1:0] o_timer_seq;
    logic                    o_last;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [THR_BITS-1:0]     i_cfg_data = '0;

    // predicted sender state
    logic [SW-1:0]       win_base = SW'(1);
    logic [SW-1:0]       win_next = SW'(1);
    logic [PW-1:0]       win_ring [WIN];
    logic [THR_BITS-1:0] dup_acks = '0;
    logic [THR_BITS-1:0] dup_threshold = THR_RESET;

    // sequence tracking used to shape stimulus
    logic [SW-1:0] gen_base = SW'(1);
    logic [SW-1:0] gen_next = SW'(1);

    link_req_t    pending_reqs [$];
    link_result_t expected_tx [$];

    int mismatch_count = 0;
    int result_count = 0;
    int accepted_reqs = 0;
    int queued_reqs = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit calm_tail = 1'b0;
    bit hold_req = 1'b0;

    sliding_window_sender u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_payload     (i_payload),
        .i_ack_number  (i_ack_number),
        .i_checksum_ok (i_checksum_ok),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_accepted    (o_accepted),
        .o_window_full (o_window_full),
        .o_tx_valid    (o_tx_valid),
        .o_tx_seq      (o_tx_seq),
        .o_tx_payload  (o_tx_payload),
        .o_timer_cmd   (o_timer_cmd),
        .o_timer_seq   (o_timer_seq),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic link_result_t make_result(logic acc, logic txv, logic [SW-1:0] seq,
                                                 logic [PW-1:0] pay, t_timer_cmd cmd,
                                                 logic [SW-1:0] tseq);
        link_result_t r;
        r.accepted    = acc;
        r.window_full = 1'b0;
        r.tx_valid    = txv;
        r.tx_seq      = txv ? OUT_SEQ_BITS'(seq) : '0;
        r.tx_payload  = txv ? pay : '0;
        r.timer_cmd   = cmd;
        r.timer_seq   = (cmd != TMR_NONE) ? OUT_SEQ_BITS'(tseq) : '0;
        r.last        = 1'b0;
        return r;
    endfunction

    task automatic predict_sender_step(link_req_t it);
        link_result_t batch [$];
        logic [SW-1:0] outs;
        logic [SW-1:0] off;
        logic [SW-1:0] ack_s;
        logic [SW-1:0] prev_base;
        logic [SW-1:0] old_base;
        logic [SW-1:0] seq_i;
        int src;
        outs = win_next - win_base;
        ack_s = SW'(it.ack_number);
        off = ack_s - win_base;
        prev_base = win_base - SW'(1);
        case (it.req_type)
            REQ_SEND: begin
                if (outs < WIN) begin
                    win_ring[outs] = it.payload;
                    batch.push_back(make_result(1'b1, 1'b1, win_next, it.payload,
                                                (outs == 0) ? TMR_START : TMR_NONE, win_next));
                    win_next = win_next + SW'(1);
                end else begin
                    batch.push_back(make_result(1'b0, 1'b0, '0, '0, TMR_NONE, '0));
                end
            end
            REQ_ACK: begin
                if (it.checksum_ok && off < outs) begin
                    for (int i = 0; i < WIN; i++) begin
                        src = i + int'(off) + 1;
                        win_ring[i] = (src < WIN) ? win_ring[src] : '0;
                    end
                    old_base = win_base;
                    win_base = ack_s + SW'(1);
                    dup_acks = '0;
                    if (win_base == win_next)
                        batch.push_back(make_result(1'b0, 1'b0, '0, '0, TMR_STOP, old_base));
                    else
                        batch.push_back(make_result(1'b0, 1'b0, '0, '0, TMR_RESTART, win_base));
                end else if (it.checksum_ok && outs > 0 && ack_s == prev_base) begin
                    dup_acks = dup_acks + THR_BITS'(1);
                    if (dup_acks >= dup_threshold) begin
                        dup_acks = '0;
                        batch.push_back(make_result(1'b0, 1'b1, win_base, win_ring[0],
                                                    TMR_RESTART, win_base));
                    end else begin
                        batch.push_back(make_result(1'b0, 1'b0, '0, '0, TMR_NONE, '0));
                    end
                end else begin
                    batch.push_back(make_result(1'b0, 1'b0, '0, '0, TMR_NONE, '0));
                end
            end
            REQ_TIMEOUT: begin
                if (outs == 0) begin
                    batch.push_back(make_result(1'b0, 1'b0, '0, '0, TMR_NONE, '0));
                end else begin
                    for (int i = 0; i < outs; i++) begin
                        seq_i = win_base + SW'(i);
                        batch.push_back(make_result(1'b0, 1'b1, seq_i, win_ring[i],
                                                    (i == 0) ? TMR_RESTART : TMR_NONE,
                                                    win_base));
                    end
                end
            end
            default: batch.push_back(make_result(1'b0, 1'b0, '0, '0, TMR_NONE, '0));
        endcase
        outs = win_next - win_base;
        foreach (batch[i]) begin
            batch[i].window_full = (outs >= WIN);
            batch[i].last = (i == batch.size() - 1);
            expected_tx.push_back(batch[i]);
        end
    endtask

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(string name, logic [PW-1:0] got, logic [PW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      result_count, name, got, want));
    endtask

    always @(posedge i_clk) begin : request_driver
        link_req_t head;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_sender_step(pending_reqs.pop_front());
                accepted_reqs++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 13);
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    head = pending_reqs[0];
                    i_req_type    <= head.req_type;
                    i_payload     <= head.payload;
                    i_ack_number  <= head.ack_number;
                    i_checksum_ok <= head.checksum_ok;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        link_result_t want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_tx.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_count));
                end else begin
                    want = expected_tx.pop_front();
                    check_field("accepted", o_accepted, want.accepted);
                    check_field("window_full", o_window_full, want.window_full);
                    check_field("tx_valid", o_tx_valid, want.tx_valid);
                    check_field("tx_seq", o_tx_seq, want.tx_seq);
                    check_field("tx_payload", o_tx_payload, want.tx_payload);
                    check_field("timer_cmd", o_timer_cmd, want.timer_cmd);
                    check_field("timer_seq", o_timer_seq, want.timer_seq);
                    check_field("last", o_last, want.last);
                end
                result_count++;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                i_out_stall <= 1'b1;
            end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 13);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the request side backs up
    initial begin
        wait (accepted_reqs >= 60);
        @(posedge i_clk);
        hold_req <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_req <= 1'b0;
    end

    task automatic queue_item(t_req req, logic [PW-1:0] pay, logic [ACK_BITS-1:0] ack,
                              logic ok);
        link_req_t it;
        logic [SW-1:0] outs;
        logic [SW-1:0] off;
        outs = gen_next - gen_base;
        off = SW'(ack) - gen_base;
        if (req == REQ_SEND && outs < WIN)
            gen_next = gen_next + SW'(1);
        if (req == REQ_ACK && ok && off < outs)
            gen_base = SW'(ack) + SW'(1);
        it.req_type = req;
        it.payload = pay;
        it.ack_number = ack;
        it.checksum_ok = ok;
        pending_reqs.push_back(it);
        queued_reqs++;
    endtask

    task automatic run_episode(int thr);
        logic [SW-1:0] outs;
        int bursts;
        int thr_eff;
        thr_eff = (thr == 0) ? 1 : thr;
        if ($urandom_range(0, 99) < 65) begin
            repeat ($urandom_range(1, WIN))
                queue_item(REQ_SEND, $urandom, $urandom, $urandom_range(0, 1));
            outs = gen_next - gen_base;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    if (outs > 0)
                        queue_item(REQ_ACK, $urandom,
                                   gen_base + SW'($urandom_range(0, outs - 1)), 1'b1);
                end
                5, 6: begin
                    bursts = $urandom_range(0, 1) ? thr_eff : $urandom_range(1, thr_eff);
                    repeat (bursts)
                        queue_item(REQ_ACK, $urandom, gen_base - SW'(1), 1'b1);
                    queue_item(REQ_ACK, $urandom, gen_next - SW'(1), 1'b1);
                end
                7, 8: begin
                    queue_item(REQ_TIMEOUT, $urandom, $urandom, $urandom_range(0, 1));
                    queue_item(REQ_ACK, $urandom, gen_next - SW'(1), 1'b1);
                end
                default: ;
            endcase
        end else begin
            queue_item(t_req'($urandom_range(0, 3)), $urandom,
                       $urandom_range(0, 1) ? ACK_BITS'($urandom)
                                            : gen_base + SW'($urandom_range(0, 6)) - SW'(2),
                       $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_in_valid || expected_tx.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        dup_threshold = value;
    endtask

    initial begin : stimulus
        int phase;
        int chunk_start;
        int directed_reqs;
        logic [THR_BITS-1:0] thr;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty window: timeout, duplicate with nothing outstanding, idle request
        queue_item(REQ_TIMEOUT, '0, '0, 1'b0);
        queue_item(REQ_ACK, '0, 8'h00, 1'b1);
        queue_item(REQ_NOP, '1, 8'hff, 1'b1);
        // fill the window, then one rejected send
        queue_item(REQ_SEND, '0, '0, 1'b0);
        queue_item(REQ_SEND, '1, 8'hff, 1'b1);
        queue_item(REQ_SEND, 32'ha5a5_5a5a, 8'h55, 1'b0);
        queue_item(REQ_SEND, 32'h5a5a_a5a5, 8'haa, 1'b1);
        queue_item(REQ_SEND, 32'h0000_0001, 8'h01, 1'b1);
        // bad checksum, duplicates up to fast retransmit, stale and out-of-range acks
        queue_item(REQ_ACK, '0, 8'h02, 1'b0);
        repeat (3) queue_item(REQ_ACK, '0, 8'h00, 1'b1);
        queue_item(REQ_ACK, '0, 8'hff, 1'b1);
        queue_item(REQ_ACK, '0, 8'h05, 1'b1);
        // full timeout, partial slide, one duplicate, full slide
        queue_item(REQ_TIMEOUT, '0, '0, 1'b1);
        queue_item(REQ_ACK, '0, 8'h02, 1'b1);
        queue_item(REQ_ACK, '0, 8'h02, 1'b1);
        queue_item(REQ_ACK, '0, 8'h04, 1'b1);
        queue_item(REQ_TIMEOUT, '0, '0, 1'b0);
        queue_item(REQ_SEND, 32'hdead_beef, '0, 1'b0);
        queue_item(REQ_SEND, 32'h1234_5678, '0, 1'b0);
        queue_item(REQ_ACK, '0, 8'h06, 1'b0);
        queue_item(REQ_TIMEOUT, '0, '0, 1'b0);
        queue_item(REQ_ACK, '0, 8'h06, 1'b1);
        wait_drained();
        directed_reqs = queued_reqs;

        phase = 0;
        while (queued_reqs - directed_reqs < 200) begin
            case (phase)
                0: thr = THR_BITS'(1);
                1: thr = THR_BITS'(15);
                2: thr = THR_BITS'(0);
                default: thr = THR_BITS'($urandom_range(0, 15));
            endcase
            write_threshold(thr);
            chunk_start = queued_reqs;
            while (queued_reqs - chunk_start < 55)
                run_episode(thr);
            wait_drained();
            phase++;
        end

        // closing stretch without idling
        write_threshold(THR_RESET);
        calm_tail = 1'b1;
        chunk_start = queued_reqs;
        while (queued_reqs - chunk_start < 40)
            run_episode(THR_RESET);
        wait_drained();
        repeat (30) @(posedge i_clk);

        if (mismatch_count == 0 && expected_tx.size() == 0)
            $display("sliding_window_sender regression: pass");
        else
            $display("sliding_window_sender regression: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("sliding_window_sender regression: fail");
        $finish;
    end

endmodule
